[sv/spc_pkg.sv]
// Shared constants, types and register codes of the stick percolation block.
package spc_pkg;

  // Store geometry and coordinate format
  localparam int MAX_SEGMENTS = 128;
  localparam int COORD_BITS   = 18;
  localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
  localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);

  // Widths of the side-test arithmetic
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int SIDE_BITS = PROD_BITS + 1;

  // Register and result field widths
  localparam int SWEEP_BITS     = 8;
  localparam int GROUP_BITS     = 7;
  localparam int COUNT_BITS     = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;

  // Register reset values
  localparam logic [SWEEP_BITS-1:0] SWEEP_COUNT_RESET   = SWEEP_BITS'(100);
  localparam logic [GROUP_BITS-1:0] GROUP_A_FIRST_RESET = GROUP_BITS'(10);
  localparam logic [GROUP_BITS-1:0] GROUP_A_LAST_RESET  = GROUP_BITS'(19);
  localparam logic [GROUP_BITS-1:0] GROUP_B_FIRST_RESET = GROUP_BITS'(20);
  localparam logic [GROUP_BITS-1:0] GROUP_B_LAST_RESET  = GROUP_BITS'(29);

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SWEEP_COUNT   = CFG_INDEX_BITS'(0),
    CFG_GROUP_A_FIRST = CFG_INDEX_BITS'(1),
    CFG_GROUP_A_LAST  = CFG_INDEX_BITS'(2),
    CFG_GROUP_B_FIRST = CFG_INDEX_BITS'(3),
    CFG_GROUP_B_LAST  = CFG_INDEX_BITS'(4)
  } cfg_reg_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One stored segment
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_t;

  // Tag that travels with a pair through the crossing test
  typedef struct packed {
    logic                valid;
    logic [IDX_BITS-1:0] index;
  } tag_t;

endpackage

[sv/spc_seg_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module spc_seg_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/spc_cross.sv]
// Three-stage pipelined two-sided straddle test between two segments.
module spc_cross
  import spc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  seg_t seg_a,
  input  seg_t seg_b,
  input  tag_t tag_in,
  output tag_t hit,
  output logic busy
);

  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SIDE_BITS-1:0] side_t;

  tag_t  tag1, tag2;
  diff_t diff      [2][6];
  diff_t diff_next [2][6];
  prod_t prod      [2][4];
  logic  straddle  [2];

  function automatic diff_t sub(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  // True unless both sides are strictly of the same sign
  function automatic logic apart(side_t s1, side_t s2);
    logic neg1, neg2, pos1, pos2;
    neg1 = s1[SIDE_BITS-1];
    neg2 = s2[SIDE_BITS-1];
    pos1 = !neg1 && (s1 != '0);
    pos2 = !neg2 && (s2 != '0);
    return !((pos1 && pos2) || (neg1 && neg2));
  endfunction

  // Differences for both directions: the line of p against the ends of q
  always_comb begin
    seg_t p, q;
    for (int d = 0; d < 2; d++) begin
      p = (d == 0) ? seg_a : seg_b;
      q = (d == 0) ? seg_b : seg_a;
      diff_next[d][0] = sub(p.sx, p.ex);
      diff_next[d][1] = sub(p.sy, p.ey);
      diff_next[d][2] = sub(q.sy, p.sy);
      diff_next[d][3] = sub(p.sx, q.sx);
      diff_next[d][4] = sub(q.ey, p.sy);
      diff_next[d][5] = sub(p.sx, q.ex);
    end
  end

  // Sum the products into side values and test both directions
  always_comb begin
    side_t s1, s2;
    for (int d = 0; d < 2; d++) begin
      s1 = side_t'(prod[d][0]) + side_t'(prod[d][1]);
      s2 = side_t'(prod[d][2]) + side_t'(prod[d][3]);
      straddle[d] = apart(s1, s2);
    end
  end

  // Advance the tags and hold the arithmetic payload of each stage
  always_ff @(posedge clk) begin
    tag1.index <= tag_in.index;
    tag2.index <= tag1.index;
    hit.index  <= tag2.index;
    for (int d = 0; d < 2; d++) begin
      for (int k = 0; k < 6; k++) begin
        diff[d][k] <= diff_next[d][k];
      end
      prod[d][0] <= diff[d][0] * diff[d][2];
      prod[d][1] <= diff[d][1] * diff[d][3];
      prod[d][2] <= diff[d][0] * diff[d][4];
      prod[d][3] <= diff[d][1] * diff[d][5];
    end
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      hit.valid  <= 1'b0;
    end else begin
      tag1.valid <= tag_in.valid;
      tag2.valid <= tag1.valid;
      hit.valid  <= tag2.valid && straddle[0] && straddle[1];
    end
  end

  assign busy = tag1.valid || tag2.valid || hit.valid;

endmodule

[sv/stick_percolation_connectivity_top.sv]
// Top level: segment store, sweep sequencer, summary pass and configuration registers.
//
//   channel  direction  handshake              beat carries
//   in       sink       in_valid / in_ready    start_x start_y end_x end_y is_seed last_segment
//   out      source     out_valid / out_ready  reached_a reached_b connected_count overflow
//   cfg      sink       cfg_write              cfg_index cfg_data
//
// Segments load at one beat per cycle into the segment RAM while the block is loading. With
// n loaded segments, each sweep reads every source in turn and skips an unconnected one; a
// connected source has its segment captured, then sends its n targets one pair per cycle into
// the crossing pipeline and waits for the pipeline to drain. A summary pass over the n flags
// follows the last sweep. Reset is synchronous; the connected flags sit in a one-bit RAM
// that every stored beat writes, so nothing needs clearing. Input stalls during sweeps and
// summary; a result waits in its register while the next set loads, and a beat that ends a
// set stalls until it is taken.
module stick_percolation_connectivity_top
  import spc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                      is_seed,
  input  logic                      last_segment,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      reached_a,
  output logic                      reached_b,
  output logic [COUNT_BITS-1:0]     connected_count,
  output logic                      overflow,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_IRD,
    S_ICAP,
    S_JRUN,
    S_DRAIN,
    S_SUM
  } state_t;

  state_t state;

  logic [SWEEP_BITS-1:0] sweep_count;
  logic [GROUP_BITS-1:0] group_a_first, group_a_last, group_b_first, group_b_last;

  logic [CNT_BITS-1:0]     loaded;
  logic                    dropped;
  logic [CNT_BITS-1:0]     i_cnt, j_cnt;
  logic [SWEEP_BITS-1:0]   s_cnt;
  logic                    sum_v;
  logic [IDX_BITS-1:0]     sum_idx;

  seg_t                seg_i;
  seg_t                rd_seg;
  seg_t                wr_seg;
  logic                wr_en;
  logic [IDX_BITS-1:0] rd_addr;
  logic                flag_we;
  logic [IDX_BITS-1:0] flag_wa;
  logic                flag_wd;
  logic                flag_rd;
  tag_t                tag_q;
  tag_t                tag_issue;
  tag_t                hit;
  logic                cross_busy;
  logic                in_fire, out_fire;
  logic                in_a, in_b;

  assign in_ready = (state == S_LOAD) && (!out_valid || !last_segment);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign wr_seg  = '{sx: start_x, sy: start_y, ex: end_x, ey: end_y};
  assign wr_en   = in_fire && (loaded < CNT_BITS'(MAX_SEGMENTS));
  assign rd_addr = (state == S_JRUN) ? j_cnt[IDX_BITS-1:0] : i_cnt[IDX_BITS-1:0];

  // Flag writes: seed bit on load, set on a crossing found by the pipeline
  assign flag_we = wr_en || hit.valid;
  assign flag_wa = hit.valid ? hit.index : loaded[IDX_BITS-1:0];
  assign flag_wd = hit.valid || is_seed;

  // Issue a pair only when the target read back as unconnected
  assign tag_issue = '{valid: tag_q.valid && !flag_rd, index: tag_q.index};

  // Group membership of the summary index
  assign in_a = (32'(sum_idx) >= 32'(group_a_first)) && (32'(sum_idx) <= 32'(group_a_last));
  assign in_b = (32'(sum_idx) >= 32'(group_b_first)) && (32'(sum_idx) <= 32'(group_b_last));

  spc_seg_ram #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH ($bits(seg_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (loaded[IDX_BITS-1:0]),
    .wr_data (wr_seg),
    .rd_addr (rd_addr),
    .rd_data (rd_seg)
  );

  spc_seg_ram #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (1)
  ) u_flags (
    .clk     (clk),
    .wr_en   (flag_we),
    .wr_addr (flag_wa),
    .wr_data (flag_wd),
    .rd_addr (rd_addr),
    .rd_data (flag_rd)
  );

  spc_cross u_cross (
    .clk    (clk),
    .rst    (rst),
    .seg_a  (seg_i),
    .seg_b  (rd_seg),
    .tag_in (tag_issue),
    .hit    (hit),
    .busy   (cross_busy)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_count   <= SWEEP_COUNT_RESET;
      group_a_first <= GROUP_A_FIRST_RESET;
      group_a_last  <= GROUP_A_LAST_RESET;
      group_b_first <= GROUP_B_FIRST_RESET;
      group_b_last  <= GROUP_B_LAST_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SWEEP_COUNT:   sweep_count   <= cfg_data[SWEEP_BITS-1:0];
        CFG_GROUP_A_FIRST: group_a_first <= cfg_data[GROUP_BITS-1:0];
        CFG_GROUP_A_LAST:  group_a_last  <= cfg_data[GROUP_BITS-1:0];
        CFG_GROUP_B_FIRST: group_b_first <= cfg_data[GROUP_BITS-1:0];
        CFG_GROUP_B_LAST:  group_b_last  <= cfg_data[GROUP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the source segment once its read returns
  always_ff @(posedge clk) begin
    if (state == S_ICAP) begin
      seg_i <= rd_seg;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      loaded          <= '0;
      dropped         <= 1'b0;
      i_cnt           <= '0;
      j_cnt           <= '0;
      s_cnt           <= '0;
      sum_v           <= 1'b0;
      sum_idx         <= '0;
      tag_q           <= '0;
      out_valid       <= 1'b0;
      reached_a       <= 1'b0;
      reached_b       <= 1'b0;
      connected_count <= '0;
      overflow        <= 1'b0;
    end else begin
      tag_q.valid <= 1'b0;

      // Drop the result once taken
      if (out_fire) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (wr_en) begin
              loaded <= loaded + CNT_BITS'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last_segment) begin
              i_cnt           <= '0;
              s_cnt           <= '0;
              reached_a       <= 1'b0;
              reached_b       <= 1'b0;
              connected_count <= '0;
              state           <= (sweep_count != '0) ? S_IRD : S_SUM;
            end
          end
        end

        S_IRD: begin
          if (i_cnt == loaded) begin
            i_cnt <= '0;
            s_cnt <= s_cnt + SWEEP_BITS'(1);
            if (s_cnt + SWEEP_BITS'(1) == sweep_count) begin
              state <= S_SUM;
            end
          end else begin
            state <= S_ICAP;
          end
        end

        // Source flag and segment are back: run the targets or skip the source
        S_ICAP: begin
          if (flag_rd) begin
            j_cnt <= '0;
            state <= S_JRUN;
          end else begin
            i_cnt <= i_cnt + CNT_BITS'(1);
            state <= S_IRD;
          end
        end

        S_JRUN: begin
          tag_q.valid <= 1'b1;
          tag_q.index <= j_cnt[IDX_BITS-1:0];
          j_cnt       <= j_cnt + CNT_BITS'(1);
          if (j_cnt + CNT_BITS'(1) == loaded) begin
            state <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          if (!tag_q.valid && !cross_busy) begin
            i_cnt <= i_cnt + CNT_BITS'(1);
            state <= S_IRD;
          end
        end

        // Read flags in order; count each one in the cycle after its read
        S_SUM: begin
          if (sum_v && flag_rd) begin
            if (connected_count != '1) begin
              connected_count <= connected_count + COUNT_BITS'(1);
            end
            if (in_a) begin
              reached_a <= 1'b1;
            end
            if (in_b) begin
              reached_b <= 1'b1;
            end
          end
          if (i_cnt == loaded) begin
            sum_v <= 1'b0;
            if (!sum_v) begin
              overflow  <= dropped;
              out_valid <= 1'b1;
              loaded    <= '0;
              dropped   <= 1'b0;
              state     <= S_LOAD;
            end
          end else begin
            sum_v   <= 1'b1;
            sum_idx <= i_cnt[IDX_BITS-1:0];
            i_cnt   <= i_cnt + CNT_BITS'(1);
          end
        end

        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

[sim/stick_percolation_connectivity_top_tb.sv]
// Self-checking testbench of the stick percolation block: directed and random segment sets.
module stick_percolation_connectivity_top_tb;
  import spc_pkg::*;

  // One summary beat as the block reports it
  typedef struct packed {
    logic                  reached_a;
    logic                  reached_b;
    logic [COUNT_BITS-1:0] count;
    logic                  overflow;
  } span_result_t;

  // Keeps its own copy of the stick store and predicts each summary beat
  class percolation_scoreboard;
    bit [SWEEP_BITS-1:0] sweeps;
    bit [GROUP_BITS-1:0] a_first, a_last, b_first, b_last;
    longint x0[MAX_SEGMENTS], y0[MAX_SEGMENTS], x1[MAX_SEGMENTS], y1[MAX_SEGMENTS];
    bit linked[MAX_SEGMENTS];
    int fill;
    bit spilled;
    span_result_t awaited[$];
    int unsigned errors, beats, sets, checked, spill_sets, hits_a, hits_b;

    function new();
      sweeps  = 100;
      a_first = 10;
      a_last  = 19;
      b_first = 20;
      b_last  = 29;
    endfunction

    function void configure(int unsigned sw, int unsigned af, int unsigned al,
                            int unsigned bf, int unsigned bl);
      sweeps  = sw;
      a_first = af;
      a_last  = al;
      b_first = bf;
      b_last  = bl;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Sign of the cross product that places point q against the line through stick p
    function int side_sign(int p, longint qx, longint qy);
      longint v;
      v = (x0[p] - x1[p]) * (qy - y0[p]) + (y0[p] - y1[p]) * (x0[p] - qx);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Stick q is not wholly on one side of the line through stick p
    function bit straddles(int p, int q);
      int s1, s2;
      s1 = side_sign(p, x0[q], y0[q]);
      s2 = side_sign(p, x1[q], y1[q]);
      return !(s1 * s2 > 0);
    endfunction

    function bit group_hit(int first, int upto);
      for (int k = first; k <= upto && k < fill; k++)
        if (linked[k]) return 1'b1;
      return 1'b0;
    endfunction

    task report(string what);
      $display("MISMATCH %s", what);
      errors++;
    endtask

    // Store an accepted segment beat; on the closing beat run the sweeps and queue the summary
    function void note_segment(longint sx, longint sy, longint ex, longint ey,
                               bit seed, bit closing);
      int i, j, total;
      bit grew;
      span_result_t res;
      beats++;
      if (fill < MAX_SEGMENTS) begin
        x0[fill] = sx;
        y0[fill] = sy;
        x1[fill] = ex;
        y1[fill] = ey;
        linked[fill] = seed;
        fill++;
      end else begin
        spilled = 1'b1;
      end
      if (!closing) return;
      // Propagate; a stick linked mid-sweep acts as a source later in the same sweep
      for (int s = 0; s < sweeps; s++) begin
        grew = 1'b0;
        for (i = 0; i < fill; i++)
          if (linked[i])
            for (j = 0; j < fill; j++)
              if (!linked[j] && straddles(i, j) && straddles(j, i)) begin
                linked[j] = 1'b1;
                grew = 1'b1;
              end
        // a sweep that links nothing leaves every later sweep unchanged
        if (!grew) break;
      end
      total = 0;
      for (i = 0; i < fill; i++)
        if (linked[i]) total++;
      res.count     = (total > 255) ? 8'd255 : COUNT_BITS'(total);
      res.reached_a = group_hit(a_first, a_last);
      res.reached_b = group_hit(b_first, b_last);
      res.overflow  = spilled;
      awaited.push_back(res);
      sets++;
      spill_sets += spilled;
      hits_a += res.reached_a;
      hits_b += res.reached_b;
      // Clear the set for the next one
      for (i = 0; i < MAX_SEGMENTS; i++) linked[i] = 1'b0;
      fill = 0;
      spilled = 1'b0;
    endfunction

    // Compare a taken summary beat with the oldest prediction
    task check_result(logic ra, logic rb, logic [COUNT_BITS-1:0] cnt, logic ovf);
      span_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("summary with none awaited: count %0d", cnt));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (ra !== want.reached_a)
        report($sformatf("summary %0d reached_a %b, want %b", checked, ra, want.reached_a));
      if (rb !== want.reached_b)
        report($sformatf("summary %0d reached_b %b, want %b", checked, rb, want.reached_b));
      if (cnt !== want.count)
        report($sformatf("summary %0d connected_count %0d, want %0d", checked, cnt, want.count));
      if (ovf !== want.overflow)
        report($sformatf("summary %0d overflow %b, want %b", checked, ovf, want.overflow));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid, in_ready;
  coord_t start_x, start_y, end_x, end_y;
  logic is_seed, last_segment;
  logic out_valid, out_ready;
  logic reached_a, reached_b, overflow;
  logic [COUNT_BITS-1:0] connected_count;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  percolation_scoreboard sb;
  int unsigned settings;

  stick_percolation_connectivity_top dut (.*);

  always #1 clk = ~clk;

  // Score every beat on both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result(reached_a, reached_b, connected_count, overflow);
      if (in_valid && in_ready)
        sb.note_segment(start_x, start_y, end_x, end_y, is_seed, last_segment);
    end
  end

  function automatic seg_t stick_at(int sx, int sy, int ex, int ey);
    seg_t st;
    st.sx = coord_t'(sx);
    st.sy = coord_t'(sy);
    st.ex = coord_t'(ex);
    st.ey = coord_t'(ey);
    return st;
  endfunction

  function automatic coord_t rand_coord(int unsigned reach);
    return coord_t'(int'($urandom_range(0, 2 * reach - 1)) - int'(reach));
  endfunction

  // Random stick inside a box; now and then zero length, on the x axis or vertical
  function automatic seg_t random_stick(int unsigned reach);
    seg_t st;
    st.sx = rand_coord(reach);
    st.sy = rand_coord(reach);
    st.ex = rand_coord(reach);
    st.ey = rand_coord(reach);
    case ($urandom_range(0, 15))
      0: begin
        st.ex = st.sx;
        st.ey = st.sy;
      end
      1: begin
        st.sy = '0;
        st.ey = '0;
      end
      2: begin
        st.ex = st.sx;
      end
      default: ;
    endcase
    return st;
  endfunction

  // Offer one segment beat after an idle gap and hold it until it is taken
  task automatic send_stick(seg_t st, bit seed, bit closing, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    start_x      <= st.sx;
    start_y      <= st.sy;
    end_x        <= st.ex;
    end_y        <= st.ey;
    is_seed      <= seed;
    last_segment <= closing;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drive one random set of n sticks; the last beat closes the set
  task automatic send_set(int unsigned n);
    int unsigned reach, seed_odds;
    bit burst;
    case ($urandom_range(0, 3))
      0: reach = 131072;
      1: reach = 8192;
      2: reach = 512;
      default: reach = 4;
    endcase
    seed_odds = $urandom_range(2, 8);
    burst = ($urandom_range(0, 3) == 0);
    for (int unsigned m = 0; m < n; m++)
      send_stick(random_stick(reach), $urandom_range(0, seed_odds - 1) == 0, m == n - 1,
                 burst ? 0 : $urandom_range(0, 17));
  endtask

  // Write all five registers back to back while the block is idle
  task automatic load_registers(int unsigned sw, int unsigned af, int unsigned al,
                                int unsigned bf, int unsigned bl);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SWEEP_COUNT;
    cfg_data  <= CFG_DATA_BITS'(sw);
    @(negedge clk);
    cfg_index <= CFG_GROUP_A_FIRST;
    cfg_data  <= CFG_DATA_BITS'(af);
    @(negedge clk);
    cfg_index <= CFG_GROUP_A_LAST;
    cfg_data  <= CFG_DATA_BITS'(al);
    @(negedge clk);
    cfg_index <= CFG_GROUP_B_FIRST;
    cfg_data  <= CFG_DATA_BITS'(bf);
    @(negedge clk);
    cfg_index <= CFG_GROUP_B_LAST;
    cfg_data  <= CFG_DATA_BITS'(bl);
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.configure(sw, af, al, bf, bl);
    settings++;
  endtask

  // Drop valid, wait until every awaited summary has been taken, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Take summaries with a random stall before each; hold off for a long stretch twice
  initial begin : take_results
    int unsigned stall, taken;
    out_ready = 1'b0;
    taken = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (taken == 25 || taken == 80)
        stall = 700;
      else if ($urandom_range(0, 3) == 0)
        stall = 0;
      else
        stall = $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // Abandon a run that hangs
  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_items, phase, n, sw, af, al, bf, bl, pick, set_total;
    bit spill;
    sb = new();
    settings = 0;
    in_valid = 1'b0;
    start_x = '0;
    start_y = '0;
    end_x = '0;
    end_y = '0;
    is_seed = 1'b0;
    last_segment = 1'b0;
    cfg_write = 1'b0;
    cfg_index = CFG_SWEEP_COUNT;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one seed stick spanning the extreme corners
    send_stick(stick_at(-131072, -131072, 131071, 131071), 1'b1, 1'b1, 0);
    drain();

    // No sweeps: only the seed flags count
    load_registers(0, 0, 0, 1, 1);
    send_stick(stick_at(-100, 0, 100, 0), 1'b0, 1'b0, 0);
    send_stick(stick_at(0, -100, 0, 100), 1'b1, 1'b1, 3);
    drain();

    // One sweep: a chain in ascending order links fully, in descending order only partly
    load_registers(1, 2, 2, 127, 127);
    send_stick(stick_at(0, 0, 1000, 0), 1'b1, 1'b0, 0);
    send_stick(stick_at(500, -10, 500, 1000), 1'b0, 1'b0, 0);
    send_stick(stick_at(0, 900, 1000, 900), 1'b0, 1'b1, 0);
    send_stick(stick_at(0, 900, 1000, 900), 1'b0, 1'b0, 2);
    send_stick(stick_at(500, -10, 500, 1000), 1'b0, 1'b0, 0);
    send_stick(stick_at(0, 0, 1000, 0), 1'b1, 1'b1, 1);
    drain();

    // Most sweeps, empty group A, group B over every index: collinear, touching, points
    load_registers(255, 5, 3, 0, 127);
    send_stick(stick_at(0, 0, 10, 0), 1'b1, 1'b0, 0);
    send_stick(stick_at(100, 0, 200, 0), 1'b0, 1'b0, 0);
    send_stick(stick_at(200, 0, 300, 50), 1'b0, 1'b0, 0);
    send_stick(stick_at(5000, 5000, 5000, 5000), 1'b0, 1'b0, 0);
    send_stick(stick_at(7000, 0, 7000, 0), 1'b0, 1'b1, 0);
    send_stick(stick_at(131071, -131072, -131072, 131071), 1'b1, 1'b0, 4);
    send_stick(stick_at(-131072, -131072, 131071, 131071), 1'b0, 1'b1, 0);
    drain();

    // Random phases; two of them overfill the store
    random_items = 0;
    phase = 0;
    while (random_items < 1650) begin
      spill = (phase == 3 || phase == 11);
      pick = $urandom_range(0, 9);
      if (spill)
        sw = $urandom_range(1, 2);
      else if (pick == 0)
        sw = 0;
      else if (pick == 1)
        sw = 255;
      else if (pick == 2)
        sw = $urandom_range(7, 40);
      else
        sw = $urandom_range(1, 6);
      // keep groups mostly among the low indices that small sets reach
      af = $urandom_range(0, 12);
      al = $urandom_range(0, 20);
      bf = $urandom_range(0, 12);
      bl = $urandom_range(0, 20);
      if ($urandom_range(0, 3) == 0) begin
        af = $urandom_range(0, 127);
        bl = $urandom_range(0, 127);
      end
      if (spill) begin
        bf = $urandom_range(100, 127);
        bl = 127;
      end
      load_registers(sw, af, al, bf, bl);
      if (spill)
        set_total = 1;
      else if (sw > 40)
        set_total = 3;
      else
        set_total = $urandom_range(4, 12);
      repeat (set_total) begin
        if (spill)
          n = $urandom_range(129, 140);
        else if (sw > 40)
          n = $urandom_range(1, 3);
        else if (sw > 6)
          n = $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0)
          n = $urandom_range(17, 32);
        else
          n = $urandom_range(1, 16);
        send_set(n);
        random_items += n;
      end
      drain();
      phase++;
    end

    repeat (200) @(negedge clk);
    $display("Run covered %0d segment beats in %0d sets over %0d register settings",
             sb.beats, sb.sets, settings + 1);
    $display("%0d summaries checked: %0d overfilled, %0d reached group A, %0d reached group B",
             sb.checked, sb.spill_sets, sb.hits_a, sb.hits_b);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
